// File: rtl/jahe_pkg.sv
// Shared types, constants and register codes for the joystick event generator.
package jahe_pkg;

  localparam int AXIS_COUNT = 8;
  localparam int HAT_COUNT  = 4;
  localparam int OVR_SLOTS  = 8;
  localparam int QDEPTH     = 8;

  localparam int AXIS_IW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int HAT_IW  = (HAT_COUNT > 1) ? $clog2(HAT_COUNT) : 1;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [6:0] PCT_MAX     = 7'd100;
  localparam logic [6:0] PCT_DEFAULT = 7'd40;
  localparam int         RECIP_SH    = 30;
  localparam logic [23:0] RECIP      = 24'((64'd1 << RECIP_SH) / 64'd100);

  localparam logic signed [15:0] CAL_MIN_RST = -16'sd32767;
  localparam logic signed [15:0] CAL_MAX_RST = 16'sd32767;

  localparam logic signed [15:0] SNAP_EDGE0 = -16'sd24576;
  localparam logic signed [15:0] SNAP_EDGE1 = -16'sd8192;
  localparam logic signed [15:0] SNAP_EDGE2 = 16'sd8192;
  localparam logic signed [15:0] SNAP_EDGE3 = 16'sd24576;
  localparam logic signed [15:0] SNAP_PT0   = -16'sd32768;
  localparam logic signed [15:0] SNAP_PT1   = -16'sd16384;
  localparam logic signed [15:0] SNAP_PT2   = 16'sd0;
  localparam logic signed [15:0] SNAP_PT3   = 16'sd16383;
  localparam logic signed [15:0] SNAP_PT4   = 16'sd32767;

  typedef enum logic [1:0] {
    ACT_AXIS    = 2'd0,
    ACT_BUTTON  = 2'd1,
    ACT_HAT     = 2'd2,
    ACT_CAPTURE = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    CFG_RUN_MODE = 3'd0,
    CFG_DEF_PCT  = 3'd1,
    CFG_NEG_TBL  = 3'd2,
    CFG_POS_TBL  = 3'd3,
    CFG_OVR_EN   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] index;
    logic       dir;
    logic       pressed;
  } slot_t;

  typedef struct packed {
    logic             is_axis;
    logic [3:0]       mask;
    slot_t [3:0]      slot;
  } entry_t;

  typedef struct packed {
    logic                valid;
    logic                axis;
    entry_t              ent;
    logic signed [15:0]  v;
    logic signed [15:0]  old;
    logic signed [15:0]  cen;
    logic signed [15:0]  cmin;
    logic signed [15:0]  cmax;
    logic [6:0]          pn;
    logic [6:0]          pp;
  } front_t;

  typedef struct packed {
    logic       is_axis;
    logic [7:0] index;
    logic       dir;
    logic       pressed;
    logic       last;
  } res_t;

endpackage

// File: rtl/jahe_front.sv
// Front end: accepts items, holds config and per-axis and per-hat state, classifies items.
module jahe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_item_index,
  input  logic signed [15:0]   in_axis_value,
  input  logic [3:0]           in_hat_bits,
  input  logic                 in_button_pressed,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [55:0]          cfg_data,
  input  logic                 credit_ret,
  output jahe_pkg::front_t     fr_o
);
  import jahe_pkg::*;

  logic                      run_mode_r;
  logic [6:0]                def_pct_r;
  logic [55:0]               neg_tbl_r;
  logic [55:0]               pos_tbl_r;
  logic [15:0]               ovr_en_r;

  logic signed [15:0]        last_r [AXIS_COUNT];
  logic signed [15:0]        min_r  [AXIS_COUNT];
  logic signed [15:0]        max_r  [AXIS_COUNT];
  logic signed [15:0]        cen_r  [AXIS_COUNT];
  logic [3:0]                hat_r  [HAT_COUNT];

  logic [QCNT_W-1:0]         cnt_r, cnt_nxt;
  front_t                    fr_r, fr_nxt;

  act_e                      act;
  logic                      accept;
  logic                      axis_ok, hat_ok, ovr_slot;
  logic [AXIS_IW-1:0]        ai;
  logic [HAT_IW-1:0]         hi;
  logic [2:0]                oi;
  logic [7:0]                pos_en;
  logic [6:0]                pn_raw, pp_raw;
  logic [3:0]                ob, hx;
  logic [7:0]                vert, horz;

  function automatic logic signed [15:0] snap(input logic signed [15:0] c);
    logic signed [15:0] r;
    if (c < SNAP_EDGE0) r = SNAP_PT0;
    else if (c < SNAP_EDGE1) r = SNAP_PT1;
    else if (c < SNAP_EDGE2) r = SNAP_PT2;
    else if (c < SNAP_EDGE3) r = SNAP_PT3;
    else r = SNAP_PT4;
    return r;
  endfunction

  assign in_full = (cnt_r == QCNT_W'(QDEPTH));
  assign accept  = in_push && !in_full;
  assign fr_o    = fr_r;

  always_comb begin
    act      = act_e'(in_action);
    axis_ok  = in_item_index < 8'(AXIS_COUNT);
    hat_ok   = in_item_index < 8'(HAT_COUNT);
    ovr_slot = in_item_index < 8'(OVR_SLOTS);
    ai       = in_item_index[AXIS_IW-1:0];
    hi       = in_item_index[HAT_IW-1:0];
    oi       = in_item_index[2:0];
    pos_en   = ovr_en_r[15:8];

    pn_raw = def_pct_r;
    pp_raw = def_pct_r;
    if (!run_mode_r && ovr_slot) begin
      if (ovr_en_r[oi]) pn_raw = neg_tbl_r[oi*7 +: 7];
      if (pos_en[oi]) pp_raw = pos_tbl_r[oi*7 +: 7];
    end

    ob   = hat_r[hi];
    hx   = in_hat_bits ^ ob;
    vert = 8'(AXIS_COUNT) + {in_item_index[6:0], 1'b0};
    horz = vert + 8'd1;

    fr_nxt       = '0;
    fr_nxt.valid = accept;
    fr_nxt.v     = in_axis_value;
    fr_nxt.old   = last_r[ai];
    fr_nxt.cen   = cen_r[ai];
    fr_nxt.cmin  = min_r[ai];
    fr_nxt.cmax  = max_r[ai];
    fr_nxt.pn    = (pn_raw > PCT_MAX) ? PCT_MAX : pn_raw;
    fr_nxt.pp    = (pp_raw > PCT_MAX) ? PCT_MAX : pp_raw;

    case (act)
      ACT_AXIS: begin
        fr_nxt.axis        = axis_ok;
        fr_nxt.ent.is_axis = 1'b1;
        fr_nxt.ent.slot[0] = '{index: in_item_index, dir: 1'b0, pressed: 1'b1};
        fr_nxt.ent.slot[1] = '{index: in_item_index, dir: 1'b0, pressed: 1'b0};
        fr_nxt.ent.slot[2] = '{index: in_item_index, dir: 1'b1, pressed: 1'b1};
        fr_nxt.ent.slot[3] = '{index: in_item_index, dir: 1'b1, pressed: 1'b0};
      end
      ACT_BUTTON: begin
        fr_nxt.ent.mask    = 4'b0001;
        fr_nxt.ent.slot[0] = '{index: in_item_index, dir: 1'b0,
                              pressed: in_button_pressed};
      end
      ACT_HAT: begin
        fr_nxt.ent.is_axis = 1'b1;
        fr_nxt.ent.mask    = hat_ok ? {hx[1], hx[3], hx[2], hx[0]} : 4'b0000;
        fr_nxt.ent.slot[0] = '{index: vert, dir: 1'b1, pressed: in_hat_bits[0]};
        fr_nxt.ent.slot[1] = '{index: vert, dir: 1'b0, pressed: in_hat_bits[2]};
        fr_nxt.ent.slot[2] = '{index: horz, dir: 1'b0, pressed: in_hat_bits[3]};
        fr_nxt.ent.slot[3] = '{index: horz, dir: 1'b1, pressed: in_hat_bits[1]};
      end
      default: ;
    endcase

    case ({accept, credit_ret})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r <= 1'b0;
      def_pct_r  <= PCT_DEFAULT;
      neg_tbl_r  <= '0;
      pos_tbl_r  <= '0;
      ovr_en_r   <= '0;
      cnt_r      <= '0;
      fr_r       <= '0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        last_r[i] <= '0;
        min_r[i]  <= CAL_MIN_RST;
        max_r[i]  <= CAL_MAX_RST;
        cen_r[i]  <= '0;
      end
      for (int i = 0; i < HAT_COUNT; i++) begin
        hat_r[i] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
      fr_r  <= fr_nxt;
      if (cfg_valid) begin
        case (cfg_idx_e'(cfg_index))
          CFG_RUN_MODE: run_mode_r <= cfg_data[0];
          CFG_DEF_PCT:  def_pct_r  <= cfg_data[6:0];
          CFG_NEG_TBL:  neg_tbl_r  <= cfg_data;
          CFG_POS_TBL:  pos_tbl_r  <= cfg_data;
          CFG_OVR_EN:   ovr_en_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (accept) begin
        case (act)
          ACT_AXIS: begin
            if (axis_ok) begin
              last_r[ai] <= in_axis_value;
              if (run_mode_r) begin
                if (in_axis_value < min_r[ai]) min_r[ai] <= in_axis_value;
                if (in_axis_value > max_r[ai]) max_r[ai] <= in_axis_value;
              end
            end
          end
          ACT_HAT: begin
            if (hat_ok) hat_r[hi] <= in_hat_bits;
          end
          ACT_CAPTURE: begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
              cen_r[i] <= snap(last_r[i]);
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/jahe_trip.sv
// Trip point pipeline: scale travel by percent, divide by 100, clamp, and mark crossings.
module jahe_trip (
  input  logic              clk,
  input  logic              rst_n,
  input  jahe_pkg::front_t  fr_i,
  output logic              push,
  output jahe_pkg::entry_t  push_ent
);
  import jahe_pkg::*;

  typedef struct packed {
    logic               valid;
    logic               axis;
    entry_t             ent;
    logic signed [15:0] v;
    logic signed [15:0] old;
    logic signed [15:0] cen;
  } ctl_t;

  ctl_t                ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl0;
  logic signed [16:0]  dlo, dhi;
  logic signed [23:0]  plo_nxt, phi_nxt, plo_r, phi_r;
  logic [22:0]         mlo, mhi, mlo_r, mhi_r;
  logic [46:0]         rlo, rhi;
  logic [15:0]         qlo_r, qhi_r;
  logic                nlo_r, nhi_r;
  logic [22:0]         remlo, remhi;
  logic [16:0]         cqlo, cqhi;
  logic signed [17:0]  tlo_nxt, thi_nxt, tlo_r, thi_r;
  logic signed [17:0]  lo_nxt, hi_nxt, lo_r, hi_r;
  logic signed [17:0]  v18, o18;

  always_comb begin
    ctl0 = '{valid: fr_i.valid, axis: fr_i.axis, ent: fr_i.ent,
             v: fr_i.v, old: fr_i.old, cen: fr_i.cen};
    dlo = 17'(fr_i.cmin) - 17'(fr_i.cen);
    dhi = 17'(fr_i.cmax) - 17'(fr_i.cen);
    plo_nxt = 24'(dlo) * 24'($signed({1'b0, fr_i.pn}));
    phi_nxt = 24'(dhi) * 24'($signed({1'b0, fr_i.pp}));

    mlo = plo_r[23] ? 23'(-plo_r) : plo_r[22:0];
    mhi = phi_r[23] ? 23'(-phi_r) : phi_r[22:0];
    rlo = 47'(mlo) * 47'(RECIP);
    rhi = 47'(mhi) * 47'(RECIP);

    remlo = mlo_r - 23'(qlo_r) * 23'd100;
    remhi = mhi_r - 23'(qhi_r) * 23'd100;
    cqlo  = (remlo >= 23'd100) ? 17'(qlo_r) + 17'd1 : 17'(qlo_r);
    cqhi  = (remhi >= 23'd100) ? 17'(qhi_r) + 17'd1 : 17'(qhi_r);
    tlo_nxt = nlo_r ? -$signed({1'b0, cqlo}) : $signed({1'b0, cqlo});
    thi_nxt = nhi_r ? -$signed({1'b0, cqhi}) : $signed({1'b0, cqhi});

    lo_nxt = (tlo_r >= 0) ? 18'(ctl3_r.cen) - 18'sd1 : 18'(ctl3_r.cen) + tlo_r;
    hi_nxt = (thi_r <= 0) ? 18'(ctl3_r.cen) + 18'sd1 : 18'(ctl3_r.cen) + thi_r;

    v18 = 18'(ctl4_r.v);
    o18 = 18'(ctl4_r.old);
    push     = ctl4_r.valid;
    push_ent = ctl4_r.ent;
    if (ctl4_r.axis) begin
      push_ent.mask[0] = (v18 <= lo_r) && (o18 > lo_r);
      push_ent.mask[1] = (v18 > lo_r) && (o18 <= lo_r);
      push_ent.mask[2] = (v18 >= hi_r) && (o18 < hi_r);
      push_ent.mask[3] = (v18 < hi_r) && (o18 >= hi_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl1_r <= ctl0;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    mlo_r <= mlo;
    mhi_r <= mhi;
    nlo_r <= plo_r[23];
    nhi_r <= phi_r[23];
    qlo_r <= rlo[RECIP_SH +: 16];
    qhi_r <= rhi[RECIP_SH +: 16];
    tlo_r <= tlo_nxt;
    thi_r <= thi_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

endmodule

// File: rtl/jahe_fifo.sv
// Classified-item queue between the front end and the event serializer.
module jahe_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jahe_pkg::entry_t  push_ent,
  input  logic              pop,
  output logic              empty,
  output jahe_pkg::entry_t  head
);
  import jahe_pkg::*;

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QCNT_W-1:0]   cnt_r;

  function automatic logic [QPTR_W-1:0] inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= inc(wp_r);
      if (pop) rp_r <= inc(rp_r);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) mem_r[wp_r] <= push_ent;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < QCNT_W'(QDEPTH)) || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

// File: rtl/jahe_back.sv
// Back end: serializes the events of each queued item into the output register.
module jahe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  jahe_pkg::entry_t  q_head,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output jahe_pkg::res_t    res_o
);
  import jahe_pkg::*;

  logic [3:0]  done_r, done_nxt;
  logic        out_vld_r, out_vld_nxt;
  res_t        res_r, res_nxt;
  logic [3:0]  pending, onehot, rest;
  logic [1:0]  sel;
  logic        slot_free, emit;
  slot_t       slot;

  assign out_empty = !out_vld_r;
  assign res_o     = res_r;

  always_comb begin
    pending = q_head.mask & ~done_r;
    onehot  = pending & (~pending + 4'd1);
    rest    = pending & ~onehot;
    if (onehot[0]) sel = 2'd0;
    else if (onehot[1]) sel = 2'd1;
    else if (onehot[2]) sel = 2'd2;
    else sel = 2'd3;
    slot      = q_head.slot[sel];
    slot_free = !out_vld_r || out_pop;
    emit      = !q_empty && (pending != 4'b0) && slot_free;
    q_pop     = !q_empty && ((pending == 4'b0) || (slot_free && rest == 4'b0));

    if (q_pop) done_nxt = 4'b0;
    else if (emit) done_nxt = done_r | onehot;
    else done_nxt = done_r;

    if (emit) out_vld_nxt = 1'b1;
    else if (out_pop) out_vld_nxt = 1'b0;
    else out_vld_nxt = out_vld_r;

    res_nxt = '{is_axis: q_head.is_axis, index: slot.index, dir: slot.dir,
                pressed: slot.pressed, last: (rest == 4'b0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      done_r    <= done_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (emit) res_r <= res_nxt;
  end

  a_done_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> ((done_r & ~q_head.mask) == 4'b0))
    else $error("emitted events outside head mask");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && rest == 4'b0) |=> (done_r == 4'b0))
    else $error("progress not cleared after last event");
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> (done_r == 4'b0))
    else $error("progress held with empty queue");

endmodule

// File: rtl/joystick_axis_hat_event_generator.sv
// Top level of the joystick axis, hat and button event generator.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_push / in_full    | action, item_index, axis_value, hat_bits, button
//  out     | out_pop / out_empty  | is_axis, event_index, direction, pressed, last
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (cfg_ready is always high)
//
// One item enters per cycle while in_full is low; the trip point pipeline carries it
// through the front register and the ctl1_r to ctl4_r stages into the queue; its first
// result is registered once the serializer and the output register are free. Each result
// takes one output cycle when not stalled; an item with no results is popped without one.
// in_full follows an 8-entry credit count covering the pipeline and the queue.
// Synchronous reset clears control and state; data registers are left unreset.
module joystick_axis_hat_event_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_action,
  input  logic [7:0]          in_item_index,
  input  logic signed [15:0]  in_axis_value,
  input  logic [3:0]          in_hat_bits,
  input  logic                in_button_pressed,
  output logic                out_empty,
  input  logic                out_pop,
  output logic                out_is_axis,
  output logic [7:0]          out_event_index,
  output logic                out_direction,
  output logic                out_pressed,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [55:0]         cfg_data
);
  import jahe_pkg::*;

  front_t  fr;
  logic    push, q_pop, q_empty;
  entry_t  push_ent, q_head;
  res_t    res;

  assign cfg_ready = 1'b1;

  jahe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_action         (in_action),
    .in_item_index     (in_item_index),
    .in_axis_value     (in_axis_value),
    .in_hat_bits       (in_hat_bits),
    .in_button_pressed (in_button_pressed),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .credit_ret        (q_pop),
    .fr_o              (fr)
  );

  jahe_trip u_trip (
    .clk      (clk),
    .rst_n    (rst_n),
    .fr_i     (fr),
    .push     (push),
    .push_ent (push_ent)
  );

  jahe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  jahe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res_o     (res)
  );

  assign out_is_axis     = res.is_axis;
  assign out_event_index = res.index;
  assign out_direction   = res.dir;
  assign out_pressed     = res.pressed;
  assign out_last        = res.last;

endmodule
